>>> design/lre_pkg.sv
// ----------------------------------------------------------------------------
// lre_pkg: shared types and constants of the Lorenzo residual encoder
// Plane store geometry, register widths, register indexes and helpers.
// ----------------------------------------------------------------------------
package lre_pkg;

    // Block size limits
    localparam int MAX_DEPTH  = 64;
    localparam int MAX_HEIGHT = 16;
    localparam int MAX_WIDTH  = 16;

    // Counter and plane store address widths
    localparam int PLANE_W = $clog2(MAX_DEPTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ADDR_W  = ROW_W + COL_W;
    localparam int WORDS   = MAX_HEIGHT * MAX_WIDTH;

    // Field and register widths
    localparam int DATA_W     = 32;
    localparam int BITS_W     = 6;
    localparam int DEPTH_W    = 7;
    localparam int SIZE_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_DEPTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WIDTH  = 2'd2;

    // Reset value of every size register
    localparam int SIZE_RESET = 8;

    // Plane store request: one write and two registered reads per cycle
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } ram_req_t;

    // Bits needed to hold a value, never less than one
    function automatic logic [BITS_W-1:0] bit_width(input logic [DATA_W-1:0] v);
        logic [BITS_W-1:0] n;
        n = BITS_W'(1);
        for (int i = 0; i < DATA_W; i++)
        begin
            if (v[i])
            begin
                n = BITS_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

>>> design/lorenzo_residual_encoder.sv
// ----------------------------------------------------------------------------
// lorenzo_residual_encoder: 3-D Lorenzo residual with zigzag coding
// Raster stream of quantized values in, zigzag code and running bit width out.
// ----------------------------------------------------------------------------
// Pipeline: an accepted request passes the stage 1, 2 and 3 registers and the output register to m_tvalid.
// Throughput: one value per cycle while m_tready does not stall the output; each
// value needs three fresh neighbor reads, served by the two read ports of the two
// plane RAMs, the other four terms are reused from the preceding value of the row.
// Reset: counters, ping select and running maximum clear, sizes go to 8;
// plane RAM contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module lorenzo_residual_encoder
    import lre_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // Input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] qval
    // Output stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] code, [37:32] code_bits, [39:38] zero
    output logic                   m_tlast
);

    // Configuration registers
    logic [DEPTH_W-1:0] depth_reg;
    logic [SIZE_W-1:0]  height_reg;
    logic [SIZE_W-1:0]  width_reg;
    logic [DEPTH_W-1:0] depth_eff;
    logic [SIZE_W-1:0]  height_eff;
    logic [SIZE_W-1:0]  width_eff;

    // Position counters
    logic [PLANE_W-1:0] plane_reg, plane_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic               ping_reg, ping_next;
    logic               end_row, end_plane, end_block;

    // Handshake chain
    logic accept;
    logic ready1, ready2, ready3, out_ready;
    logic s1_go, s2_go, s3_go;

    // Plane store
    ram_req_t          req0, req1;
    logic [DATA_W-1:0] m0_a, m0_b, m1_a, m1_b;

    // Stage 1: read data back from the plane store
    logic              s1_valid_reg;
    logic [DATA_W-1:0] s1_q_reg;
    logic              s1_ping_reg;
    logic              s1_t_nz_reg, s1_h_nz_reg, s1_w_nz_reg;
    logic              s1_last_reg;
    logic [DATA_W-1:0] pa, pb, cb, d1;

    // Stage 2: difference across t and h
    logic              s2_valid_reg;
    logic [DATA_W-1:0] s2_d1_reg;
    logic              s2_w_nz_reg;
    logic              s2_last_reg;
    logic [DATA_W-1:0] prev_d1_reg;
    logic [DATA_W-1:0] dres, zz;

    // Stage 3: zigzag code
    logic              s3_valid_reg;
    logic [DATA_W-1:0] s3_code_reg;
    logic              s3_last_reg;
    logic [DATA_W-1:0] run_max_reg;
    logic [DATA_W-1:0] max_new;

    // Output register
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_code_reg;
    logic [BITS_W-1:0] out_bits_reg;
    logic              out_last_reg;

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg  <= DEPTH_W'(SIZE_RESET);
            height_reg <= SIZE_W'(SIZE_RESET);
            width_reg  <= SIZE_W'(SIZE_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BLOCK_DEPTH:  depth_reg  <= cfg_data[DEPTH_W-1:0];
                CFG_BLOCK_HEIGHT: height_reg <= cfg_data[SIZE_W-1:0];
                CFG_BLOCK_WIDTH:  width_reg  <= cfg_data[SIZE_W-1:0];
                default:          ;
            endcase
        end
    end

    // Clamp sizes: zero acts as one, oversize acts as the maximum
    always_comb
    begin
        if (depth_reg == '0)
            depth_eff = DEPTH_W'(1);
        else if (depth_reg > DEPTH_W'(MAX_DEPTH))
            depth_eff = DEPTH_W'(MAX_DEPTH);
        else
            depth_eff = depth_reg;

        if (height_reg == '0)
            height_eff = SIZE_W'(1);
        else if (height_reg > SIZE_W'(MAX_HEIGHT))
            height_eff = SIZE_W'(MAX_HEIGHT);
        else
            height_eff = height_reg;

        if (width_reg == '0)
            width_eff = SIZE_W'(1);
        else if (width_reg > SIZE_W'(MAX_WIDTH))
            width_eff = SIZE_W'(MAX_WIDTH);
        else
            width_eff = width_reg;
    end

    // Handshake chain: each stage loads when the next one is free
    assign out_ready = !out_valid_reg || m_tready;
    assign ready3    = !s3_valid_reg || out_ready;
    assign ready2    = !s2_valid_reg || ready3;
    assign ready1    = !s1_valid_reg || ready2;
    assign s3_go     = s3_valid_reg && out_ready;
    assign s2_go     = s2_valid_reg && ready3;
    assign s1_go     = s1_valid_reg && ready2;
    assign s_tready  = ready1;
    assign accept    = s_tvalid && ready1;

    // Detect row, plane and block ends
    assign end_row   = (SIZE_W'(col_reg) + SIZE_W'(1)) >= width_eff;
    assign end_plane = end_row && ((SIZE_W'(row_reg) + SIZE_W'(1)) >= height_eff);
    assign end_block = end_plane && ((DEPTH_W'(plane_reg) + DEPTH_W'(1)) >= depth_eff);

    // Advance the raster position
    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        plane_next = plane_reg;
        ping_next  = ping_reg;
        if (accept)
        begin
            if (!end_row)
            begin
                col_next = col_reg + COL_W'(1);
            end
            else
            begin
                col_next = '0;
                if (!end_plane)
                begin
                    row_next = row_reg + ROW_W'(1);
                end
                else
                begin
                    row_next  = '0;
                    ping_next = !ping_reg;
                    plane_next = end_block ? '0 : plane_reg + PLANE_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            plane_reg <= '0;
            ping_reg  <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            plane_reg <= plane_next;
            ping_reg  <= ping_next;
        end
    end

    // Plane store: write the current plane, read (h,w) and (h-1,w) of both
    always_comb
    begin
        req0.we      = accept && !ping_reg;
        req0.waddr   = {row_reg, col_reg};
        req0.wdata   = s_tdata[DATA_W-1:0];
        req0.re      = accept;
        req0.raddr_a = {row_reg, col_reg};
        req0.raddr_b = {row_reg - ROW_W'(1), col_reg};
        req1         = req0;
        req1.we      = accept && ping_reg;
    end

    lre_plane_ram u_ram0
    (
        .clk  (clk),
        .req  (req0),
        .rd_a (m0_a),
        .rd_b (m0_b)
    );

    lre_plane_ram u_ram1
    (
        .clk  (clk),
        .req  (req1),
        .rd_a (m1_a),
        .rd_b (m1_b)
    );

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            run_max_reg   <= '0;
        end
        else
        begin
            if (ready1)
                s1_valid_reg <= accept;
            if (ready2)
                s2_valid_reg <= s1_valid_reg;
            if (ready3)
                s3_valid_reg <= s2_valid_reg;
            if (out_ready)
                out_valid_reg <= s3_valid_reg;
            // Restart the running maximum after the last value of a block
            if (s3_go)
                run_max_reg <= s3_last_reg ? '0 : max_new;
        end
    end

    // Stage 1: pick previous and current plane words, difference over t and h
    always_comb
    begin
        pa = s1_ping_reg ? m0_a : m1_a;
        pb = s1_ping_reg ? m0_b : m1_b;
        cb = s1_ping_reg ? m1_b : m0_b;
        d1 = s1_q_reg
           - (s1_t_nz_reg ? pa : '0)
           - (s1_h_nz_reg ? cb : '0)
           + ((s1_t_nz_reg && s1_h_nz_reg) ? pb : '0);
    end

    // Stage 2: subtract the same difference of the left neighbor, zigzag
    assign dres = s2_d1_reg - (s2_w_nz_reg ? prev_d1_reg : '0);
    assign zz   = {dres[DATA_W-2:0], 1'b0} ^ {DATA_W{dres[DATA_W-1]}};

    // Stage 3: update the running maximum
    assign max_new = (s3_code_reg > run_max_reg) ? s3_code_reg : run_max_reg;

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_q_reg    <= s_tdata[DATA_W-1:0];
            s1_ping_reg <= ping_reg;
            s1_t_nz_reg <= plane_reg != '0;
            s1_h_nz_reg <= row_reg != '0;
            s1_w_nz_reg <= col_reg != '0;
            s1_last_reg <= end_block;
        end
        if (s1_go)
        begin
            s2_d1_reg   <= d1;
            s2_w_nz_reg <= s1_w_nz_reg;
            s2_last_reg <= s1_last_reg;
        end
        if (s2_go)
        begin
            prev_d1_reg <= s2_d1_reg;
            s3_code_reg <= zz;
            s3_last_reg <= s2_last_reg;
        end
        if (s3_go)
        begin
            out_code_reg <= s3_code_reg;
            out_bits_reg <= bit_width(max_new);
            out_last_reg <= s3_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - DATA_W - BITS_W){1'b0}}, out_bits_reg, out_code_reg};
    assign m_tlast  = out_last_reg;

    // Bit count of a result is always in range
    a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_bits_reg != '0) && (out_bits_reg <= BITS_W'(DATA_W)))
        else $error("bit count out of range");

    // Running maximum restarts after the last value of a block
    a_max_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_go && s3_last_reg) |=> (run_max_reg == '0))
        else $error("running maximum not cleared at block end");

    // Ping select flips only at the end of a plane
    a_ping_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && end_plane) |=> $stable(ping_reg))
        else $error("ping select changed inside a plane");

    // A stalled stage 1 keeps its item
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !ready2) |=> s1_valid_reg && $stable(s1_q_reg))
        else $error("stage 1 item lost under stall");

    // Column counter stays below MAX_WIDTH after a request
    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (SIZE_W'(col_reg) < SIZE_W'(MAX_WIDTH)))
        else $error("column counter out of range");

endmodule

>>> design/lre_plane_ram.sv
// ----------------------------------------------------------------------------
// lre_plane_ram: one plane of the ping-pong plane store
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module lre_plane_ram
    import lre_pkg::*;
(
    input  logic              clk,
    input  ram_req_t          req,
    output logic [DATA_W-1:0] rd_a,
    output logic [DATA_W-1:0] rd_b
);

    logic [DATA_W-1:0] mem [WORDS];
    logic [DATA_W-1:0] rd_a_reg;
    logic [DATA_W-1:0] rd_b_reg;

    // Write the new value, read both neighbor rows
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_a_reg <= mem[req.raddr_a];
            rd_b_reg <= mem[req.raddr_b];
        end
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule
